FILE: rtl/u8u16_pkg.sv
package u8u16_pkg;

  // Report status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Work for the back part caused by one accepted byte
  typedef struct packed {
    logic [1:0]  n_units;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        rep;
    logic [1:0]  status;
    logic [15:0] count;
  } entry_t;

endpackage

FILE: rtl/u8u16_front.sv
module u8u16_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output logic                q_push,
  output u8u16_pkg::entry_t   q_data
);

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_SEQ       = 3'd1;
  localparam logic [2:0] MODE_SEQ_NOFIT = 3'd2;
  localparam logic [2:0] MODE_STOPPED   = 3'd3;
  localparam logic [2:0] MODE_ERROR     = 3'd4;

  localparam logic [32:0] CMAX    = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [32:0] RST_EXT = (33'h0FFFF > CMAX) ? CMAX : 33'h0FFFF;

  logic [15:0]            output_limit;
  logic [2:0]             mode, mode_next;
  logic [1:0]             bytes_pending, bytes_pending_next;
  logic [20:0]            code_point, code_point_next;
  logic [1:0]             lead_class, lead_class_next;
  logic                   second_byte_due, second_byte_due_next;
  logic [COUNT_WIDTH-1:0] units_left, units_left_next;
  logic [COUNT_WIDTH-1:0] units_written, units_written_next;

  logic [32:0]            lim_ext, lim_sat, cfg_ext, cfg_sat;
  logic [COUNT_WIDTH-1:0] limit_load, cfg_load;

  // Saturate the limit to the count width
  assign lim_ext    = 33'(output_limit);
  assign lim_sat    = (lim_ext > CMAX) ? CMAX : lim_ext;
  assign limit_load = lim_sat[COUNT_WIDTH-1:0];
  assign cfg_ext    = 33'(cfg_data);
  assign cfg_sat    = (cfg_ext > CMAX) ? CMAX : cfg_ext;
  assign cfg_load   = cfg_sat[COUNT_WIDTH-1:0];

  always_comb begin
    logic        bad;
    logic        emit_en;
    logic [20:0] emit_cp;
    logic [20:0] vsub;
    logic [1:0]  cls;
    logic [2:0]  payload;
    logic [4:0]  payload5;
    logic [32:0] uw_ext;

    mode_next            = mode;
    bytes_pending_next   = bytes_pending;
    code_point_next      = code_point;
    lead_class_next      = lead_class;
    second_byte_due_next = second_byte_due;
    units_left_next      = units_left;
    units_written_next   = units_written;
    q_data               = '0;
    bad                  = 1'b0;
    emit_en              = 1'b0;
    emit_cp              = '0;
    vsub                 = '0;
    cls                  = 2'd1;
    payload              = '0;
    payload5             = '0;
    uw_ext               = '0;

    case (mode)
      MODE_IDLE: begin
        if (units_left == '0) begin
          mode_next = MODE_STOPPED;
        end else if (!data_byte[7]) begin
          emit_en = 1'b1;
          emit_cp = 21'(data_byte);
        end else if (data_byte[7:6] != 2'b11 || data_byte inside {[8'hF8:8'hFF]}) begin
          mode_next = MODE_ERROR;
        end else begin
          if (data_byte inside {[8'hF0:8'hF7]}) begin
            cls      = 2'd3;
            payload5 = {2'b00, data_byte[2:0]};
          end else if (data_byte inside {[8'hE0:8'hEF]}) begin
            cls      = 2'd2;
            payload5 = {1'b0, data_byte[3:0]};
          end else begin
            cls      = 2'd1;
            payload5 = data_byte[4:0];
          end
          payload = payload5[2:0];
          if (last_byte) begin
            mode_next = MODE_ERROR;
          end else if (cls == 2'd1 && data_byte[4:1] == 4'd0) begin
            mode_next = MODE_ERROR;
          end else if (cls == 2'd3 && payload > 3'd4) begin
            mode_next = MODE_ERROR;
          end else begin
            code_point_next      = 21'(payload5);
            lead_class_next      = cls;
            bytes_pending_next   = cls;
            second_byte_due_next = 1'b1;
            // A pair needs two units of budget
            mode_next = (cls == 2'd3 && units_left == COUNT_WIDTH'(1)) ?
                        MODE_SEQ_NOFIT : MODE_SEQ;
          end
        end
      end
      MODE_SEQ, MODE_SEQ_NOFIT: begin
        if (second_byte_due) begin
          if (lead_class == 2'd2 && code_point == '0 && !data_byte[5]) bad = 1'b1;
          if (lead_class == 2'd3 && code_point == '0 && data_byte[5:4] == 2'b00) bad = 1'b1;
          if (lead_class == 2'd3 && code_point == 21'd4 && data_byte[5:4] != 2'b00)
            bad = 1'b1;
          second_byte_due_next = 1'b0;
        end
        if (!bad) begin
          bytes_pending_next = bytes_pending - 2'd1;
          if (bytes_pending_next != 2'd0 && last_byte) bad = 1'b1;
        end
        if (!bad && mode == MODE_SEQ) begin
          if (data_byte[7:6] != 2'b10) bad = 1'b1;
          else code_point_next = {code_point[14:0], data_byte[5:0]};
        end
        if (bad) begin
          mode_next = MODE_ERROR;
        end else if (bytes_pending_next == 2'd0) begin
          if (mode == MODE_SEQ_NOFIT) begin
            mode_next = MODE_STOPPED;
          end else begin
            emit_en   = 1'b1;
            emit_cp   = code_point_next;
            mode_next = MODE_IDLE;
          end
        end
      end
      default: begin
        // Stopped or in error: drop bytes until the end mark
      end
    endcase

    if (emit_en) begin
      if (emit_cp < 21'h10000) begin
        q_data.n_units     = 2'd1;
        q_data.unit0       = emit_cp[15:0];
        units_left_next    = units_left - COUNT_WIDTH'(1);
        units_written_next = units_written + COUNT_WIDTH'(1);
      end else begin
        vsub               = emit_cp - 21'h10000;
        q_data.n_units     = 2'd2;
        q_data.unit0       = 16'hD800 | {6'd0, vsub[19:10]};
        q_data.unit1       = 16'hDC00 | {6'd0, vsub[9:0]};
        units_left_next    = units_left - COUNT_WIDTH'(2);
        units_written_next = units_written + COUNT_WIDTH'(2);
      end
    end

    if (last_byte) begin
      uw_ext        = 33'(units_written_next);
      q_data.rep    = 1'b1;
      q_data.count  = uw_ext[15:0];
      q_data.status = (mode_next == MODE_ERROR)   ? u8u16_pkg::ST_BAD :
                      (mode_next == MODE_STOPPED) ? u8u16_pkg::ST_LIMIT :
                                                    u8u16_pkg::ST_DONE;
      mode_next            = MODE_IDLE;
      bytes_pending_next   = '0;
      code_point_next      = '0;
      lead_class_next      = '0;
      second_byte_due_next = 1'b0;
      units_left_next      = limit_load;
      units_written_next   = '0;
    end
  end

  assign q_push = in_valid && (q_data.n_units != 2'd0 || q_data.rep);

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit    <= 16'hFFFF;
      mode            <= MODE_IDLE;
      bytes_pending   <= '0;
      code_point      <= '0;
      lead_class      <= '0;
      second_byte_due <= 1'b0;
      units_left      <= RST_EXT[COUNT_WIDTH-1:0];
      units_written   <= '0;
    end else begin
      if (in_valid) begin
        mode            <= mode_next;
        bytes_pending   <= bytes_pending_next;
        code_point      <= code_point_next;
        lead_class      <= lead_class_next;
        second_byte_due <= second_byte_due_next;
        units_left      <= units_left_next;
        units_written   <= units_written_next;
      end
      if (cfg_we) begin
        output_limit <= cfg_data;
        // Reload the budget at once if the string has not started
        if (!in_valid && mode == MODE_IDLE && units_written == '0) units_left <= cfg_load;
      end
    end
  end

endmodule

FILE: rtl/u8u16_fifo.sv
module u8u16_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8u16_pkg::entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output u8u16_pkg::entry_t rdata
);

  u8u16_pkg::entry_t              mem [u8u16_pkg::QDEPTH];
  logic [u8u16_pkg::QAW-1:0]      wptr, rptr, rptr_next;
  logic [u8u16_pkg::QAW:0]        count;

  assign full      = (count == (u8u16_pkg::QAW+1)'(u8u16_pkg::QDEPTH));
  assign empty     = (count == '0);
  assign rptr_next = pop ? rptr + 1'b1 : rptr;

  // Register the head: take the incoming entry when it lands on the next read slot
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
    rdata <= (push && wptr == rptr_next) ? wdata : mem[rptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (u8u16_pkg::QAW+1)'(u8u16_pkg::QDEPTH))
    else $error("queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from an empty queue");

endmodule

FILE: rtl/u8u16_back.sv
module u8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  u8u16_pkg::entry_t head,
  output logic              head_pop,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       code_unit,
  output logic              is_report,
  output logic [1:0]        status,
  output logic [15:0]       unit_count,
  output logic              last_result
);

  logic       out_valid;
  logic [1:0] sub;
  logic [1:0] total;
  logic       load;
  logic       sub_last;

  assign total    = head.n_units + {1'b0, head.rep};
  assign sub_last = (sub == total - 2'd1);
  assign load     = head_valid && (!out_valid || pop);
  assign head_pop = load && sub_last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= sub_last ? 2'd0 : sub + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_result <= sub_last;
      if (sub < head.n_units) begin
        code_unit  <= (sub == 2'd0) ? head.unit0 : head.unit1;
        is_report  <= 1'b0;
        status     <= u8u16_pkg::ST_DONE;
        unit_count <= '0;
      end else begin
        code_unit  <= '0;
        is_report  <= 1'b1;
        status     <= head.status;
        unit_count <= head.count;
      end
    end
  end

  a_report_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_report) |-> last_result)
    else $error("report is not the final result of its byte");

  a_unit_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_report) |-> (status == u8u16_pkg::ST_DONE && unit_count == '0))
    else $error("unit result carries report fields");

  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (sub < total))
    else $error("result index past entry size");

endmodule

FILE: rtl/utf8_to_utf16_decoder_top.sv
// Channel    Direction  Handshake              Payload
// input      in         push / full            data_byte[7:0], last_byte
// result     out        empty / pop            code_unit[15:0], is_report, status[1:0],
//                                              unit_count[15:0], last_result
// config     in         cfg_valid / cfg_ready  cfg_data[15:0] (output_limit)
//
// One byte is accepted per cycle while full is low; the front decodes it in that same
// cycle and queues its results (zero to three) into a four-entry queue.
// The back hands out one result per cycle from its output register while pop is held,
// so a byte that yields a surrogate pair plus a report gives three results in turn.
// full rises only when the four-entry queue is full; a stalled pop backs up there.
// rst is synchronous, active high; it empties the queue and output register and
// sets output_limit back to 65535. cfg_ready is always high.
module utf8_to_utf16_decoder_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic        is_report,
  output logic [1:0]  status,
  output logic [15:0] unit_count,
  output logic        last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic              accept;
  logic              q_push;
  u8u16_pkg::entry_t q_wdata;
  logic              q_empty;
  logic              q_pop;
  u8u16_pkg::entry_t q_rdata;

  assign cfg_ready = 1'b1;
  // Take a byte whenever the queue has room
  assign accept    = push && !full;

  u8u16_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Hold decoded work until the back can drain it
  u8u16_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Serialize each entry into single results
  u8u16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_empty),
    .head        (q_rdata),
    .head_pop    (q_pop),
    .empty       (empty),
    .pop         (pop),
    .code_unit   (code_unit),
    .is_report   (is_report),
    .status      (status),
    .unit_count  (unit_count),
    .last_result (last_result)
  );

endmodule
